### rtl/fmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fmc_pkg
// Shared types, codes and helper functions of the five-tuple classifier.
// ----------------------------------------------------------------------------
package fmc_pkg;

  localparam logic FUNC_CLASSIFY = 1'b0;
  localparam logic FUNC_APPEND   = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

  localparam logic [3:0] CLASS_UNKNOWN = 4'd15;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [2:0] OCTETS_ALL = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [2:0]  src_octets;
    logic [31:0] dst_addr;
    logic [2:0]  dst_octets;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        src_port_any;
    logic        dst_port_any;
    logic [7:0]  protocol;
    logic        protocol_any;
    logic [7:0]  codepoint;
  } rule_t;

  function automatic logic [7:0] phb_codepoint(input logic [3:0] cls);
    logic [7:0] cp;
    unique case (cls)
      4'd0:    cp = 8'd0;
      4'd1:    cp = 8'd184;
      4'd2:    cp = 8'd40;
      4'd3:    cp = 8'd48;
      4'd4:    cp = 8'd56;
      4'd5:    cp = 8'd72;
      4'd6:    cp = 8'd80;
      4'd7:    cp = 8'd88;
      4'd8:    cp = 8'd104;
      4'd9:    cp = 8'd112;
      4'd10:   cp = 8'd120;
      4'd11:   cp = 8'd136;
      4'd12:   cp = 8'd144;
      4'd13:   cp = 8'd152;
      4'd14:   cp = 8'd224;
      default: cp = 8'd0;
    endcase
    return cp;
  endfunction

  function automatic logic [2:0] sat_octets(input logic [2:0] octets);
    return (octets > OCTETS_ALL) ? OCTETS_ALL : octets;
  endfunction

  function automatic logic [31:0] octet_mask(input logic [2:0] octets);
    logic [31:0] m;
    unique case (octets)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'hFF00_0000;
      3'd2:    m = 32'hFFFF_0000;
      3'd3:    m = 32'hFFFF_FF00;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic rule_match(input rule_t r, input logic [31:0] sip,
                                      input logic [31:0] dip, input logic [15:0] sp,
                                      input logic [15:0] dp, input logic [7:0] pr);
    logic src_ok;
    logic dst_ok;
    logic sp_ok;
    logic dp_ok;
    logic pr_ok;
    src_ok = ((r.src_addr ^ sip) & octet_mask(r.src_octets)) == 32'd0;
    dst_ok = ((r.dst_addr ^ dip) & octet_mask(r.dst_octets)) == 32'd0;
    sp_ok  = r.src_port_any || (r.src_port == sp);
    dp_ok  = r.dst_port_any || (r.dst_port == dp);
    pr_ok  = r.protocol_any || (r.protocol == pr);
    return src_ok && dst_ok && sp_ok && dp_ok && pr_ok;
  endfunction

endpackage
`default_nettype wire

### rtl/fmc_rule_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fmc_rule_store
// Rule table memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fmc_rule_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire fmc_pkg::rule_t  wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output fmc_pkg::rule_t       rd_data
);

  fmc_pkg::rule_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/first_match_five_tuple_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_match_five_tuple_classifier
// Ordered DiffServ rule table with first-match five-tuple lookup.
// ----------------------------------------------------------------------------
// An append item stores one rule at the end of the table in a single write, unless
// the table is full, and its result goes to the output register from the finish
// state. A classify item reads the rule memory one rule per cycle in insertion
// order through its single read port and stops at the first hit; a miss reads
// every rule held before its result goes to the output register.
// One item is worked on at a time; a finished result waits in the output
// register while the next item is accepted.
module first_match_five_tuple_classifier #(
  parameter int RULES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        func,
  input  wire logic [31:0] src_ip,
  input  wire logic [31:0] dst_ip,
  input  wire logic [15:0] src_port,
  input  wire logic [15:0] dst_port,
  input  wire logic [7:0]  protocol,
  input  wire logic [2:0]  src_octets,
  input  wire logic [2:0]  dst_octets,
  input  wire logic        src_port_any,
  input  wire logic        dst_port_any,
  input  wire logic        protocol_any,
  input  wire logic [3:0]  phb_class,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             hit,
  output logic [3:0]       rule_index,
  output logic [7:0]       codepoint,
  output logic [4:0]       rules_held,
  output logic [1:0]       status
);

  localparam int IW = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int TW = $clog2(RULES + 1);

  fmc_pkg::state_t state;
  fmc_pkg::state_t state_next;

  logic [TW-1:0] total;
  logic [TW-1:0] iss;
  logic          cv;
  logic [IW-1:0] ci;

  logic [31:0] h_sip;
  logic [31:0] h_dip;
  logic [15:0] h_sp;
  logic [15:0] h_dp;
  logic [7:0]  h_pr;

  logic          res_hit;
  logic [IW-1:0] res_idx;
  logic [7:0]    res_cp;
  logic [1:0]    res_status;

  logic           accept;
  logic           full;
  logic           wr_en;
  logic           rd_en;
  logic           match;
  logic           scan_hit;
  logic           scan_done;
  logic           fin_load;
  logic           port_proto;
  fmc_pkg::rule_t wr_data;
  fmc_pkg::rule_t rd_data;

  assign full       = (total == TW'(RULES));
  assign accept     = in_valid && in_ready;
  assign wr_en      = accept && (func == fmc_pkg::FUNC_APPEND) && !full;
  assign rd_en      = (state == fmc_pkg::S_SCAN) && (iss != total);
  assign match      = fmc_pkg::rule_match(rd_data, h_sip, h_dip, h_sp, h_dp, h_pr);
  assign scan_hit   = (state == fmc_pkg::S_SCAN) && cv && match;
  assign scan_done  = (state == fmc_pkg::S_SCAN) && (iss == total);
  assign fin_load   = (state == fmc_pkg::S_FIN) && (!out_valid || out_ready);
  assign port_proto = (protocol == fmc_pkg::PROTO_TCP) || (protocol == fmc_pkg::PROTO_UDP);

  always_comb begin
    wr_data.src_addr     = src_ip;
    wr_data.src_octets   = fmc_pkg::sat_octets(src_octets);
    wr_data.dst_addr     = dst_ip;
    wr_data.dst_octets   = fmc_pkg::sat_octets(dst_octets);
    wr_data.src_port     = src_port;
    wr_data.dst_port     = dst_port;
    wr_data.src_port_any = src_port_any;
    wr_data.dst_port_any = dst_port_any;
    wr_data.protocol     = protocol;
    wr_data.protocol_any = protocol_any;
    wr_data.codepoint    = fmc_pkg::phb_codepoint(phb_class);
  end

  fmc_rule_store #(
    .DEPTH (RULES),
    .AW    (IW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (total[IW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (iss[IW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      fmc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (func == fmc_pkg::FUNC_APPEND) ? fmc_pkg::S_FIN : fmc_pkg::S_SCAN;
        end
      end
      fmc_pkg::S_SCAN: begin
        if (scan_hit || (scan_done && !cv) || (scan_done && cv && !match)) begin
          state_next = fmc_pkg::S_FIN;
        end
      end
      fmc_pkg::S_FIN: begin
        if (fin_load) begin
          state_next = fmc_pkg::S_IDLE;
        end
      end
      default: state_next = fmc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fmc_pkg::S_IDLE;
      total     <= '0;
      iss       <= '0;
      cv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        iss <= '0;
        cv  <= 1'b0;
      end else if (state == fmc_pkg::S_SCAN) begin
        cv <= rd_en;
        if (rd_en) begin
          iss <= iss + TW'(1);
        end
      end
      if (wr_en) begin
        total <= total + TW'(1);
      end
      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      h_sip      <= src_ip;
      h_dip      <= dst_ip;
      h_sp       <= port_proto ? src_port : 16'd0;
      h_dp       <= port_proto ? dst_port : 16'd0;
      h_pr       <= protocol;
      res_hit    <= 1'b0;
      res_idx    <= '0;
      res_cp     <= 8'd0;
      if ((func == fmc_pkg::FUNC_APPEND) && full) begin
        res_status <= fmc_pkg::STATUS_FULL;
      end else if ((func == fmc_pkg::FUNC_APPEND)
                   && (phb_class == fmc_pkg::CLASS_UNKNOWN)) begin
        res_status <= fmc_pkg::STATUS_UNKNOWN;
      end else begin
        res_status <= fmc_pkg::STATUS_OK;
      end
    end
    if (state == fmc_pkg::S_SCAN) begin
      ci <= iss[IW-1:0];
    end
    if (scan_hit) begin
      res_hit <= 1'b1;
      res_idx <= ci;
      res_cp  <= rd_data.codepoint;
    end
    if (fin_load) begin
      hit        <= res_hit;
      rule_index <= 4'(res_idx);
      codepoint  <= res_cp;
      rules_held <= 5'(total);
      status     <= res_status;
    end
  end

endmodule
`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the first-match five-tuple classifier
// Appends rules and classifies headers through the valid/ready channels,
// mirrors the rule table in an in-bench predictor and checks every result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 16;
  localparam int RANDOM_ITEMS = 1600;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_AFTER = 400;
  localparam int HOLD_CYCLES = 600;

  localparam logic [7:0] PHB_DSCP [0:15] = '{
    8'd0, 8'd184, 8'd40, 8'd48, 8'd56, 8'd72, 8'd80, 8'd88,
    8'd104, 8'd112, 8'd120, 8'd136, 8'd144, 8'd152, 8'd224, 8'd0
  };

  typedef struct packed {
    logic        func;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
    logic [2:0]  src_octets;
    logic [2:0]  dst_octets;
    logic        src_port_any;
    logic        dst_port_any;
    logic        protocol_any;
    logic [3:0]  phb_class;
  } item_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] rule_index;
    logic [7:0] codepoint;
    logic [4:0] rules_held;
    logic [1:0] status;
  } outcome_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = 1'b0;
  logic [31:0] src_ip = '0;
  logic [31:0] dst_ip = '0;
  logic [15:0] src_port = '0;
  logic [15:0] dst_port = '0;
  logic [7:0]  protocol = '0;
  logic [2:0]  src_octets = '0;
  logic [2:0]  dst_octets = '0;
  logic        src_port_any = 1'b0;
  logic        dst_port_any = 1'b0;
  logic        protocol_any = 1'b0;
  logic [3:0]  phb_class = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        hit;
  logic [3:0]  rule_index;
  logic [7:0]  codepoint;
  logic [4:0]  rules_held;
  logic [1:0]  status;

  item_t    pending_items [$];
  item_t    planned_rules [$];
  outcome_t expected_outcomes [$];

  fmc_pkg::rule_t rule_table [TABLE_DEPTH];
  int    rules_stored = 0;

  int       mismatches = 0;
  int       items_taken = 0;
  logic     item_taken = 1'b0;
  int       quiet_cycles = 0;
  item_t    next_item = '0;
  logic     send_now;
  int       burst_left = 0;
  int       gap_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_phase = 0;
  int       hold_left = 0;
  logic     hold_done = 1'b0;
  logic     rx_ready;
  item_t    taken_item;
  outcome_t seen;
  outcome_t want;

  first_match_five_tuple_classifier #(.RULES(TABLE_DEPTH)) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .src_ip(src_ip),
    .dst_ip(dst_ip),
    .src_port(src_port),
    .dst_port(dst_port),
    .protocol(protocol),
    .src_octets(src_octets),
    .dst_octets(dst_octets),
    .src_port_any(src_port_any),
    .dst_port_any(dst_port_any),
    .protocol_any(protocol_any),
    .phb_class(phb_class),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hit(hit),
    .rule_index(rule_index),
    .codepoint(codepoint),
    .rules_held(rules_held),
    .status(status)
  );

  always begin
    #1;
    clk = 1'b1;
    #1;
    clk = 1'b0;
  end

  function automatic logic [31:0] prefix_mask(input logic [2:0] octets);
    logic [31:0] m;
    if (octets == 3'd0) begin
      m = '0;
    end else if (octets >= fmc_pkg::OCTETS_ALL) begin
      m = '1;
    end else begin
      m = ~(32'hFFFF_FFFF >> (32'(octets) * 8));
    end
    return m;
  endfunction

  function automatic outcome_t table_step(input item_t it);
    outcome_t   res;
    logic [15:0] sp;
    logic [15:0] dp;
    fmc_pkg::rule_t r;
    int         i;
    res = '0;
    if (it.func == fmc_pkg::FUNC_APPEND) begin
      if (rules_stored >= TABLE_DEPTH) begin
        res.status = fmc_pkg::STATUS_FULL;
      end else begin
        r.src_addr     = it.src_ip;
        r.src_octets   = (it.src_octets > fmc_pkg::OCTETS_ALL) ? fmc_pkg::OCTETS_ALL
                                                                : it.src_octets;
        r.dst_addr     = it.dst_ip;
        r.dst_octets   = (it.dst_octets > fmc_pkg::OCTETS_ALL) ? fmc_pkg::OCTETS_ALL
                                                                : it.dst_octets;
        r.src_port     = it.src_port;
        r.dst_port     = it.dst_port;
        r.src_port_any = it.src_port_any;
        r.dst_port_any = it.dst_port_any;
        r.protocol     = it.protocol;
        r.protocol_any = it.protocol_any;
        r.codepoint    = PHB_DSCP[it.phb_class];
        rule_table[rules_stored] = r;
        rules_stored = rules_stored + 1;
        if (it.phb_class == fmc_pkg::CLASS_UNKNOWN) begin
          res.status = fmc_pkg::STATUS_UNKNOWN;
        end
      end
    end else begin
      sp = it.src_port;
      dp = it.dst_port;
      if (it.protocol != fmc_pkg::PROTO_TCP && it.protocol != fmc_pkg::PROTO_UDP) begin
        sp = '0;
        dp = '0;
      end
      for (i = 0; i < rules_stored; i++) begin
        r = rule_table[i];
        if (!res.hit
            && ((r.src_addr ^ it.src_ip) & prefix_mask(r.src_octets)) == 32'd0
            && ((r.dst_addr ^ it.dst_ip) & prefix_mask(r.dst_octets)) == 32'd0
            && (r.src_port_any || r.src_port == sp)
            && (r.dst_port_any || r.dst_port == dp)
            && (r.protocol_any || r.protocol == it.protocol)) begin
          res.hit        = 1'b1;
          res.rule_index = 4'(i);
          res.codepoint  = r.codepoint;
        end
      end
    end
    res.rules_held = 5'(rules_stored);
    return res;
  endfunction

  function automatic logic [7:0] pick_protocol();
    logic [7:0] pr;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: pr = fmc_pkg::PROTO_TCP;
      4, 5, 6:    pr = fmc_pkg::PROTO_UDP;
      7:          pr = 8'd1;
      default:    pr = 8'($urandom);
    endcase
    return pr;
  endfunction

  function automatic item_t noise_item();
    item_t r;
    r.func         = 1'($urandom);
    r.src_ip       = $urandom;
    r.dst_ip       = $urandom;
    r.src_port     = 16'($urandom);
    r.dst_port     = 16'($urandom);
    r.protocol     = pick_protocol();
    r.src_octets   = 3'($urandom);
    r.dst_octets   = 3'($urandom);
    r.src_port_any = 1'($urandom);
    r.dst_port_any = 1'($urandom);
    r.protocol_any = 1'($urandom);
    r.phb_class    = 4'($urandom);
    return r;
  endfunction

  function automatic item_t random_rule();
    item_t r;
    r = noise_item();
    r.func = fmc_pkg::FUNC_APPEND;
    if ($urandom_range(0, 1) == 0) begin
      r.src_ip[31:24] = 8'd10;
    end
    if ($urandom_range(0, 1) == 0) begin
      r.src_port = 16'($urandom_range(0, 1023));
    end
    if ($urandom_range(0, 1) == 0) begin
      r.dst_port = 16'($urandom_range(0, 1023));
    end
    r.src_port_any = ($urandom_range(0, 3) == 0);
    r.dst_port_any = ($urandom_range(0, 3) == 0);
    r.protocol_any = ($urandom_range(0, 3) == 0);
    if (r.protocol != fmc_pkg::PROTO_TCP && r.protocol != fmc_pkg::PROTO_UDP
        && !r.protocol_any && $urandom_range(0, 1) == 0) begin
      r.src_port = '0;
      r.dst_port = '0;
    end
    if (r.src_port_any && r.dst_port_any && r.protocol_any
        && prefix_mask(r.src_octets) == 32'd0 && prefix_mask(r.dst_octets) == 32'd0) begin
      r.protocol_any = 1'b0;
    end
    return r;
  endfunction

  function automatic item_t header_for(input item_t r);
    item_t       h;
    logic [31:0] sm;
    logic [31:0] dm;
    h = noise_item();
    h.func = fmc_pkg::FUNC_CLASSIFY;
    sm = prefix_mask(r.src_octets);
    dm = prefix_mask(r.dst_octets);
    h.src_ip = (r.src_ip & sm) | (h.src_ip & ~sm);
    h.dst_ip = (r.dst_ip & dm) | (h.dst_ip & ~dm);
    if (!r.protocol_any) begin
      h.protocol = r.protocol;
    end
    if (!r.src_port_any) begin
      h.src_port = r.src_port;
    end
    if (!r.dst_port_any) begin
      h.dst_port = r.dst_port;
    end
    if ($urandom_range(0, 6) == 0) begin
      case ($urandom_range(0, 4))
        0:       h.src_ip[$urandom_range(0, 31)] ^= 1'b1;
        1:       h.dst_ip[$urandom_range(0, 31)] ^= 1'b1;
        2:       h.src_port[$urandom_range(0, 15)] ^= 1'b1;
        3:       h.dst_port[$urandom_range(0, 15)] ^= 1'b1;
        default: h.protocol[$urandom_range(0, 7)] ^= 1'b1;
      endcase
    end
    return h;
  endfunction

  function automatic item_t header_of(input logic [31:0] s, input logic [31:0] d,
                                      input logic [15:0] sp, input logic [15:0] dp,
                                      input logic [7:0] pr);
    item_t h;
    h = '0;
    h.func     = fmc_pkg::FUNC_CLASSIFY;
    h.src_ip   = s;
    h.dst_ip   = d;
    h.src_port = sp;
    h.dst_port = dp;
    h.protocol = pr;
    return h;
  endfunction

  function automatic item_t rule_of(input logic [31:0] s, input logic [2:0] sn,
                                    input logic [31:0] d, input logic [2:0] dn,
                                    input logic [15:0] sp, input logic [15:0] dp,
                                    input logic [7:0] pr, input logic [2:0] wild,
                                    input logic [3:0] cls);
    item_t r;
    r = header_of(s, d, sp, dp, pr);
    r.func         = fmc_pkg::FUNC_APPEND;
    r.src_octets   = sn;
    r.dst_octets   = dn;
    r.src_port_any = wild[2];
    r.dst_port_any = wild[1];
    r.protocol_any = wild[0];
    r.phb_class    = cls;
    return r;
  endfunction

  function automatic void queue_item(input item_t it);
    pending_items.push_back(it);
    if (it.func == fmc_pkg::FUNC_APPEND && planned_rules.size() < TABLE_DEPTH) begin
      planned_rules.push_back(it);
    end
  endfunction

  always @(negedge clk) begin
    if (!rst && !(in_valid && !item_taken)) begin
      send_now = 1'b0;
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
      end else if (pending_items.size() > 0) begin
        next_item = pending_items.pop_front();
        send_now = 1'b1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      in_valid <= send_now;
      {func, src_ip, dst_ip, src_port, dst_port, protocol, src_octets, dst_octets,
       src_port_any, dst_port_any, protocol_any, phb_class} <= next_item;
    end
  end

  // The long hold-off fills the block and its output register so that the
  // input side stalls while items keep being offered.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left = rx_left - 1;
    end
    rx_phase = rx_phase + 1;
    if (!hold_done && items_taken >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rx_ready = 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   rx_ready = 1'b1;
        RX_COIN:   rx_ready = 1'($urandom);
        RX_SPARSE: rx_ready = (rx_phase % 4 == 0);
        default:   rx_ready = ($urandom_range(0, 7) != 0);
      endcase
    end
    out_ready <= rx_ready;
  end

  always @(posedge clk) begin
    item_taken <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        seen = {hit, rule_index, codepoint, rules_held, status};
        if (expected_outcomes.size() == 0) begin
          $error("result with no item outstanding");
          mismatches++;
        end else begin
          want = expected_outcomes.pop_front();
          if (seen.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, seen.hit);
            mismatches++;
          end
          if (seen.rule_index !== want.rule_index) begin
            $error("rule_index: expected %0d, actual %0d", want.rule_index, seen.rule_index);
            mismatches++;
          end
          if (seen.codepoint !== want.codepoint) begin
            $error("codepoint: expected %0d, actual %0d", want.codepoint, seen.codepoint);
            mismatches++;
          end
          if (seen.rules_held !== want.rules_held) begin
            $error("rules_held: expected %0d, actual %0d", want.rules_held, seen.rules_held);
            mismatches++;
          end
          if (seen.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, seen.status);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        taken_item = {func, src_ip, dst_ip, src_port, dst_port, protocol, src_octets,
                      dst_octets, src_port_any, dst_port_any, protocol_any, phb_class};
        expected_outcomes.push_back(table_step(taken_item));
        items_taken <= items_taken + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    item_t it;
    int    k;
    queue_item(header_of('0, '0, '0, '0, '0));
    it = '1;
    it.func = fmc_pkg::FUNC_CLASSIFY;
    queue_item(it);
    queue_item(rule_of(32'h0A01_0203, 3'd4, 32'hC0A8_0001, 3'd4, 16'd1234, 16'd80,
                       fmc_pkg::PROTO_TCP, 3'b000, 4'd1));
    queue_item(header_of(32'h0A01_0203, 32'hC0A8_0001, 16'd1234, 16'd80, fmc_pkg::PROTO_TCP));
    queue_item(header_of(32'h0A01_0203, 32'hC0A8_0001, 16'd1234, 16'd80, fmc_pkg::PROTO_UDP));
    queue_item(header_of(32'h0A01_0203, 32'hC0A8_0001, 16'd1234, 16'd81, fmc_pkg::PROTO_TCP));
    queue_item(rule_of('1, 3'd7, '0, 3'd0, '0, '0, 8'd1, 3'b000, fmc_pkg::CLASS_UNKNOWN));
    queue_item(header_of('1, 32'h1234_5678, 16'd5555, 16'd7777, 8'd1));
    queue_item(header_of('1, 32'h1234_5678, 16'd5555, 16'd7777, fmc_pkg::PROTO_TCP));
    queue_item(rule_of(32'hAC10_0000, 3'd2, '0, 3'd0, '0, 16'd53, fmc_pkg::PROTO_UDP,
                       3'b100, 4'd14));
    queue_item(header_of(32'hAC10_6307, 32'h0808_0808, 16'd40000, 16'd53, fmc_pkg::PROTO_UDP));
    queue_item(header_of(32'hAC11_6307, 32'h0808_0808, 16'd40000, 16'd53, fmc_pkg::PROTO_UDP));
    queue_item(rule_of(32'h0A00_0000, 3'd1, 32'hC0A8_0000, 3'd3, '0, '0, '0, 3'b111, 4'd13));
    queue_item(header_of(32'h0A01_0203, 32'hC0A8_0001, 16'd1234, 16'd80, fmc_pkg::PROTO_TCP));
    queue_item(header_of(32'h0AC8_0000, 32'hC0A8_00FE, 16'd9, 16'd9, 8'hFF));
    queue_item(rule_of('1, 3'd4, '1, 3'd4, '1, '1, fmc_pkg::PROTO_UDP, 3'b000, 4'd0));
    queue_item(header_of('1, '1, '1, '1, fmc_pkg::PROTO_UDP));
    queue_item(header_of('1, '1, '1, '1, 8'hFF));

    // Rules go in early so that most headers run against a full table.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if ($urandom_range(0, 99) < ((planned_rules.size() < TABLE_DEPTH) ? 30 : 8)) begin
        queue_item(random_rule());
      end else if ($urandom_range(0, 3) != 0) begin
        queue_item(header_for(planned_rules[$urandom_range(0, planned_rules.size() - 1)]));
      end else begin
        it = noise_item();
        it.func = fmc_pkg::FUNC_CLASSIFY;
        queue_item(it);
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (!(pending_items.size() == 0 && !in_valid && expected_outcomes.size() == 0)) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/fmc_pkg.sv
rtl/fmc_rule_store.sv
rtl/first_match_five_tuple_classifier.sv
bench/tb_top.sv
